// ===== sv/mfr_pkg.sv =====
// Shared types, constants and helper functions for the meter frame receiver.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package mfr_pkg;

	// Number of address bytes in a frame (1 to 8).
	localparam int ADDRESS_BYTES = 6;
	localparam int ADDR_W        = ADDRESS_BYTES * 8;
	localparam int ADDR_IDX_W    = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;
	localparam int METER_ADDR_W  = 48;
	localparam int ENERGY_W      = 28;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 8;

	// Frame bytes.
	localparam logic [7:0] FRAME_HEAD     = 8'h68;
	localparam logic [7:0] FRAME_TAIL     = 8'h16;
	localparam logic [7:0] WAKE_BYTE      = 8'hFE;
	localparam logic [7:0] PAYLOAD_OFFSET = 8'h33;
	localparam logic [7:0] ADDR_BYTE_MAX  = 8'hAA;
	localparam logic [7:0] CTRL_ADDR_SET  = 8'h8A;
	localparam logic [7:0] CTRL_READ_REPLY = 8'h81;
	localparam logic [15:0] REG_ID_TOTAL_ENERGY = 16'h9010;

	// Configuration register reset values.
	localparam logic [7:0] MAX_LEN_RESET       = 8'd200;
	localparam logic [2:0] TIMEOUT_LIMIT_RESET = 3'd4;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_PAYLOAD_LENGTH = 2'd0,
		REG_TIMEOUT_LIMIT      = 2'd1
	} cfg_reg_t;

	// Request opcodes; the fourth code is ignored.
	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_ARM     = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PAYLOAD = 2'd1,
		EV_FRAME   = 2'd2,
		EV_ABORT   = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		KIND_OTHER    = 2'd0,
		KIND_ADDR_SET = 2'd1,
		KIND_ENERGY   = 2'd2
	} frame_kind_t;

	// Live configuration values.
	typedef struct packed {
		logic [7:0] max_payload_length;
		logic [2:0] timeout_limit;
	} cfg_t;

	// One registered input request.
	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} item_t;

	// One result.
	typedef struct packed {
		logic [1:0]              event_res;
		logic                    reinit_link;
		logic [7:0]              payload_byte;
		logic [7:0]              payload_index;
		logic [7:0]              control_code;
		logic [METER_ADDR_W-1:0] meter_address;
		logic [7:0]              payload_length;
		logic [1:0]              frame_kind;
		logic [ENERGY_W-1:0]     energy_hundredths;
	} result_t;

	// Contribution of one decoded energy byte. Position 0 holds the two
	// lowest BCD digits; each digit weighs ten times the one below it.
	function automatic logic [ENERGY_W-1:0] energy_term(input logic [1:0] pos,
			input logic [7:0] d);
		logic [ENERGY_W-1:0] lo;
		logic [ENERGY_W-1:0] hi;
		logic [ENERGY_W-1:0] term;
		lo = ENERGY_W'(d[3:0]);
		hi = ENERGY_W'(d[7:4]);
		case (pos)
			2'd0:    term = lo + hi * ENERGY_W'(10);
			2'd1:    term = lo * ENERGY_W'(100) + hi * ENERGY_W'(1000);
			2'd2:    term = lo * ENERGY_W'(10000) + hi * ENERGY_W'(100000);
			default: term = lo * ENERGY_W'(1000000) + hi * ENERGY_W'(10000000);
		endcase
		return term;
	endfunction

endpackage

// ===== sv/mfr_ifs.sv =====
// Handshake channel interfaces for the meter frame receiver: requests in,
// results out and configuration writes. Depends on mfr_pkg.
`timescale 1ns / 1ps

interface mfr_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mfr_result_if
	import mfr_pkg::*;
	;
	logic                    valid;
	logic                    ready;
	logic [1:0]              event_res;
	logic                    reinit_link;
	logic [7:0]              payload_byte;
	logic [7:0]              payload_index;
	logic [7:0]              control_code;
	logic [METER_ADDR_W-1:0] meter_address;
	logic [7:0]              payload_length;
	logic [1:0]              frame_kind;
	logic [ENERGY_W-1:0]     energy_hundredths;

	modport source (output valid, output event_res, output reinit_link, output payload_byte,
		output payload_index, output control_code, output meter_address,
		output payload_length, output frame_kind, output energy_hundredths, input ready);
	modport sink (input valid, input event_res, input reinit_link, input payload_byte,
		input payload_index, input control_code, input meter_address,
		input payload_length, input frame_kind, input energy_hundredths, output ready);
endinterface

interface mfr_cfg_if
	import mfr_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/meter_frame_receiver_unit.sv =====
// Top level of the meter frame receiver: input register, frame parser and
// configuration registers. Depends on mfr_pkg, the interfaces and submodules.
`timescale 1ns / 1ps

// The receiver takes one request per cycle (a received byte, a receive
// timeout or an arm after a request went out) and returns exactly one result
// for each. The request waits in the input register while the parser works
// out its result, and the result register loads as the request moves on.
// The whole per-byte update of the receive state machine sits between those
// two registers, so the sustained rate is one request per clock as long as
// results are taken. While a result waits to be taken, one more request is
// accepted into the input register and further requests are held off.
// Configuration writes are taken at once and must be made only while the
// block is idle; there is no start-up sweep after reset.
module meter_frame_receiver_unit
	import mfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mfr_item_if.sink     item,
	mfr_result_if.source result,
	mfr_cfg_if.sink      cfg
);

	cfg_t  cfg_val;
	logic  take;
	logic  valid_s1;
	item_t item_s1;

	mfr_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	mfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mfr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_val  (cfg_val),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take),
		.result   (result)
	);

endmodule

// ===== sv/mfr_cfg_regs.sv =====
// Configuration registers of the meter frame receiver.
// Depends on mfr_pkg and the mfr_cfg_if interface.
`timescale 1ns / 1ps

module mfr_cfg_regs
	import mfr_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	mfr_cfg_if.sink         cfg,
	output cfg_t            cfg_val
);

	cfg_t cfg_q;

	// Writes are always taken; an unknown index is dropped.
	assign cfg.ready = 1'b1;
	assign cfg_val   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload_length <= MAX_LEN_RESET;
			cfg_q.timeout_limit      <= TIMEOUT_LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_PAYLOAD_LENGTH: cfg_q.max_payload_length <= cfg.data;
				REG_TIMEOUT_LIMIT:      cfg_q.timeout_limit      <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/mfr_in_stage.sv =====
// Input register of the meter frame receiver: holds one request until the
// parser takes it. Depends on mfr_pkg and the mfr_item_if interface.
`timescale 1ns / 1ps

module mfr_in_stage
	import mfr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	mfr_item_if.sink item,
	input  logic     take,
	output logic     valid_s1,
	output item_t    item_s1
);

	// A new request enters when the stage is empty or drains this cycle.
	assign item.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.opcode  <= item.opcode;
			item_s1.rx_byte <= item.rx_byte;
		end
	end

endmodule

// ===== sv/mfr_parser.sv =====
// Frame parser of the meter frame receiver: the receive state machine, the
// frame stores and the result register. Depends on mfr_pkg and mfr_result_if.
`timescale 1ns / 1ps

module mfr_parser
	import mfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg_val,
	input  logic         valid_s1,
	input  item_t        item_s1,
	output logic         take,
	mfr_result_if.source result
);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_HEAD_A  = 4'd1,
		PH_ADDR    = 4'd2,
		PH_HEAD_B  = 4'd3,
		PH_CONTROL = 4'd4,
		PH_LEN     = 4'd5,
		PH_DATA    = 4'd6,
		PH_SUM     = 4'd7,
		PH_TAIL    = 4'd8
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [7:0]          left_q, left_d;
	logic [7:0]          sum_q, sum_d;
	logic [ADDR_W-1:0]   addr_q, addr_d;
	logic [7:0]          ctrl_q, ctrl_d;
	logic [7:0]          len_q, len_d;
	logic [15:0]         regid_q, regid_d;
	logic [ENERGY_W-1:0] energy_q, energy_d;
	logic [3:0]          tcnt_q, tcnt_d;
	logic                out_valid_q;
	result_t             res_q, res_d;

	logic [7:0]            data_idx;
	logic [7:0]            dec_byte;
	logic [7:0]            addr_off;
	logic [ADDR_IDX_W-1:0] addr_idx;
	logic [3:0]            tcnt_inc;
	logic [7:0]            sum_add;
	logic [63:0]           addr_wide;
	logic [1:0]            kind;

	// The request moves on when the result register is free or emptied now.
	assign take = valid_s1 && (!out_valid_q || result.ready);

	// Next state and result for the request in the input register.
	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		sum_d    = sum_q;
		addr_d   = addr_q;
		ctrl_d   = ctrl_q;
		len_d    = len_q;
		regid_d  = regid_q;
		energy_d = energy_q;
		tcnt_d   = tcnt_q;
		res_d    = '0;
		kind     = KIND_OTHER;

		data_idx  = len_q - left_q;
		dec_byte  = item_s1.rx_byte - PAYLOAD_OFFSET;
		addr_off  = 8'(ADDRESS_BYTES) - left_q;
		addr_idx  = addr_off[ADDR_IDX_W-1:0];
		tcnt_inc  = tcnt_q + 4'd1;
		sum_add   = sum_q + item_s1.rx_byte;
		addr_wide = 64'(addr_q);

		case (item_s1.opcode)
			OP_ARM: begin
				phase_d = PH_HEAD_A;
				left_d  = 8'd1;
				sum_d   = 8'd0;
			end
			OP_TIMEOUT: begin
				tcnt_d = tcnt_inc;
				if (tcnt_inc > {1'b0, cfg_val.timeout_limit}) begin
					res_d.reinit_link = 1'b1;
					tcnt_d            = 4'd0;
				end
				if (phase_q != PH_IDLE) begin
					res_d.event_res = EV_ABORT;
				end
				phase_d = PH_IDLE;
				left_d  = 8'd0;
				sum_d   = 8'd0;
			end
			OP_BYTE: begin
				tcnt_d = 4'd0;
				unique case (phase_q)
					PH_IDLE: ;
					PH_HEAD_A: begin
						if (item_s1.rx_byte == FRAME_HEAD) begin
							phase_d = PH_ADDR;
							left_d  = 8'(ADDRESS_BYTES);
							sum_d   = sum_add;
							addr_d  = '0;
						end else if (item_s1.rx_byte != WAKE_BYTE) begin
							res_d.event_res = EV_ABORT;
							phase_d = PH_IDLE;
							left_d  = 8'd0;
							sum_d   = 8'd0;
						end
					end
					PH_ADDR: begin
						if (item_s1.rx_byte <= ADDR_BYTE_MAX) begin
							for (int i = 0; i < ADDRESS_BYTES; i++) begin
								if (addr_idx == ADDR_IDX_W'(i)) begin
									addr_d[i*8 +: 8] = item_s1.rx_byte;
								end
							end
							sum_d = sum_add;
							if (left_q == 8'd1) begin
								phase_d = PH_HEAD_B;
								left_d  = 8'd1;
							end else begin
								left_d = left_q - 8'd1;
							end
						end else begin
							res_d.event_res = EV_ABORT;
							phase_d = PH_IDLE;
							left_d  = 8'd0;
							sum_d   = 8'd0;
						end
					end
					PH_HEAD_B: begin
						if (item_s1.rx_byte == FRAME_HEAD) begin
							phase_d = PH_CONTROL;
							left_d  = 8'd1;
							sum_d   = sum_add;
						end else begin
							res_d.event_res = EV_ABORT;
							phase_d = PH_IDLE;
							left_d  = 8'd0;
							sum_d   = 8'd0;
						end
					end
					PH_CONTROL: begin
						ctrl_d  = item_s1.rx_byte;
						phase_d = PH_LEN;
						left_d  = 8'd1;
						sum_d   = sum_add;
					end
					PH_LEN: begin
						if (item_s1.rx_byte <= cfg_val.max_payload_length) begin
							len_d    = item_s1.rx_byte;
							regid_d  = 16'd0;
							energy_d = '0;
							sum_d    = sum_add;
							if (item_s1.rx_byte == 8'd0) begin
								phase_d = PH_SUM;
								left_d  = 8'd1;
							end else begin
								phase_d = PH_DATA;
								left_d  = item_s1.rx_byte;
							end
						end else begin
							res_d.event_res = EV_ABORT;
							phase_d = PH_IDLE;
							left_d  = 8'd0;
							sum_d   = 8'd0;
						end
					end
					PH_DATA: begin
						sum_d = sum_add;
						// The first two payload bytes are the register id, the
						// next four the energy digits.
						if (data_idx == 8'd0) begin
							regid_d[7:0] = dec_byte;
						end else if (data_idx == 8'd1) begin
							regid_d[15:8] = dec_byte;
						end else if (data_idx >= 8'd2 && data_idx <= 8'd5) begin
							energy_d = energy_q + energy_term(data_idx[1:0] - 2'd2, dec_byte);
						end
						res_d.event_res     = EV_PAYLOAD;
						res_d.payload_byte  = dec_byte;
						res_d.payload_index = data_idx;
						if (left_q <= 8'd1) begin
							phase_d = PH_SUM;
							left_d  = 8'd1;
						end else begin
							left_d = left_q - 8'd1;
						end
					end
					PH_SUM: begin
						if (item_s1.rx_byte == sum_q) begin
							phase_d = PH_TAIL;
							left_d  = 8'd1;
						end else begin
							res_d.event_res = EV_ABORT;
							phase_d = PH_IDLE;
							left_d  = 8'd0;
							sum_d   = 8'd0;
						end
					end
					PH_TAIL: begin
						if (item_s1.rx_byte == FRAME_TAIL) begin
							if (ctrl_q == CTRL_ADDR_SET) begin
								kind = KIND_ADDR_SET;
							end else if (ctrl_q == CTRL_READ_REPLY &&
									regid_q == REG_ID_TOTAL_ENERGY) begin
								kind = KIND_ENERGY;
							end
							res_d.event_res      = EV_FRAME;
							res_d.control_code   = ctrl_q;
							res_d.meter_address  = addr_wide[METER_ADDR_W-1:0];
							res_d.payload_length = len_q;
							res_d.frame_kind     = kind;
							if (kind == KIND_ENERGY) begin
								res_d.energy_hundredths = energy_q;
							end
						end else begin
							res_d.event_res = EV_ABORT;
						end
						phase_d = PH_IDLE;
						left_d  = 8'd0;
						sum_d   = 8'd0;
					end
					default: begin
						phase_d = PH_IDLE;
						left_d  = 8'd0;
						sum_d   = 8'd0;
					end
				endcase
			end
			default: ;
		endcase
	end

	// State, frame stores and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			left_q      <= 8'd0;
			sum_q       <= 8'd0;
			addr_q      <= '0;
			ctrl_q      <= 8'd0;
			len_q       <= 8'd0;
			regid_q     <= 16'd0;
			energy_q    <= '0;
			tcnt_q      <= 4'd0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			left_q      <= left_d;
			sum_q       <= sum_d;
			addr_q      <= addr_d;
			ctrl_q      <= ctrl_d;
			len_q       <= len_d;
			regid_q     <= regid_d;
			energy_q    <= energy_d;
			tcnt_q      <= tcnt_d;
			out_valid_q <= 1'b1;
			res_q       <= res_d;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.event_res         = res_q.event_res;
	assign result.reinit_link       = res_q.reinit_link;
	assign result.payload_byte      = res_q.payload_byte;
	assign result.payload_index     = res_q.payload_index;
	assign result.control_code      = res_q.control_code;
	assign result.meter_address     = res_q.meter_address;
	assign result.payload_length    = res_q.payload_length;
	assign result.frame_kind        = res_q.frame_kind;
	assign result.energy_hundredths = res_q.energy_hundredths;

endmodule
